>>> hdl/frustum_aabb_cull_unit_assert.svh
// ----------------------------------------------------------------------------
// Frustum cull assertion macros
// Shared shorthand for the concurrent checks of the frustum cull unit.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_AABB_CULL_UNIT_ASSERT_SVH
`define FRUSTUM_AABB_CULL_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define FAC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fac_pkg.sv
// ----------------------------------------------------------------------------
// Frustum cull package
// Types, widths and codes shared by the frustum cull unit.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int NumPlanes = 6;
  localparam int NumComps  = 4;
  localparam int NumAxes   = 3;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // Q16.16 coordinate, widened plane component, exact product and sum
  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] comp_t;
  typedef logic signed [64:0] prod_t;
  typedef logic signed [66:0] acc_t;

endpackage

>>> hdl/fac_in_if.sv
// ----------------------------------------------------------------------------
// Frustum cull input channel
// Valid/ready channel carrying one load or test transaction.
// ----------------------------------------------------------------------------
interface fac_in_if;
  logic           valid;
  logic           ready;
  logic           op;
  logic [1:0]     col_index;
  fac_pkg::coord_t col_elem0;
  fac_pkg::coord_t col_elem1;
  fac_pkg::coord_t col_elem2;
  fac_pkg::coord_t col_elem3;
  fac_pkg::coord_t box_min_x;
  fac_pkg::coord_t box_min_y;
  fac_pkg::coord_t box_min_z;
  fac_pkg::coord_t box_max_x;
  fac_pkg::coord_t box_max_y;
  fac_pkg::coord_t box_max_z;

  modport source (
    output valid, op, col_index, col_elem0, col_elem1, col_elem2, col_elem3,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );

  modport sink (
    input  valid, op, col_index, col_elem0, col_elem1, col_elem2, col_elem3,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

>>> hdl/fac_out_if.sv
// ----------------------------------------------------------------------------
// Frustum cull result channel
// Valid/ready channel carrying one visibility result per test transaction.
// ----------------------------------------------------------------------------
interface fac_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (
    output valid, visible,
    input  ready
  );

  modport sink (
    input  valid, visible,
    output ready
  );
endinterface

>>> hdl/fac_plane_store.sv
// ----------------------------------------------------------------------------
// Frustum cull plane store
// Six planes of four components; a column load writes one component of all.
// ----------------------------------------------------------------------------
module fac_plane_store (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [1:0]      col_index_i,
  input  fac_pkg::coord_t elem_i  [fac_pkg::NumComps],
  output fac_pkg::comp_t  plane_o [fac_pkg::NumPlanes][fac_pkg::NumComps]
);

  fac_pkg::comp_t planes_q [fac_pkg::NumPlanes][fac_pkg::NumComps];

  for (genvar p = 0; p < fac_pkg::NumPlanes; p++) begin : g_plane
    // left/right use row 0, bottom/top row 1, near/far row 2
    localparam int RowSel = p / 2;
    fac_pkg::comp_t comp_d;

    // even planes add the row to row 3, odd planes subtract it
    always_comb begin
      if ((p % 2) == 1) begin
        comp_d = fac_pkg::comp_t'(elem_i[3]) - fac_pkg::comp_t'(elem_i[RowSel]);
      end else begin
        comp_d = fac_pkg::comp_t'(elem_i[3]) + fac_pkg::comp_t'(elem_i[RowSel]);
      end
    end

    for (genvar c = 0; c < fac_pkg::NumComps; c++) begin : g_comp
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          planes_q[p][c] <= '0;
        end else if (we_i && (col_index_i == 2'(c))) begin
          planes_q[p][c] <= comp_d;
        end
      end
      assign plane_o[p][c] = planes_q[p][c];
    end
  end

endmodule

>>> hdl/fac_plane_lane.sv
// ----------------------------------------------------------------------------
// Frustum cull plane lane
// One plane test: positive-vertex products registered, then exact sum sign.
// ----------------------------------------------------------------------------
module fac_plane_lane (
  input  logic            clk_i,
  input  logic            en_i,
  input  fac_pkg::comp_t  plane_i   [fac_pkg::NumComps],
  input  fac_pkg::coord_t box_min_i [fac_pkg::NumAxes],
  input  fac_pkg::coord_t box_max_i [fac_pkg::NumAxes],
  output logic            reject_o
);

  fac_pkg::prod_t prod_d [fac_pkg::NumAxes];
  fac_pkg::prod_t prod_q [fac_pkg::NumAxes];
  fac_pkg::comp_t dist_q;
  logic           zero_d, zero_q;
  fac_pkg::acc_t  acc;

  // pick the corner furthest along the normal and multiply per axis
  for (genvar a = 0; a < fac_pkg::NumAxes; a++) begin : g_axis
    fac_pkg::coord_t corner;
    assign corner    = plane_i[a][32] ? box_min_i[a] : box_max_i[a];
    assign prod_d[a] = fac_pkg::prod_t'(plane_i[a]) * fac_pkg::prod_t'(corner);
  end

  assign zero_d = (plane_i[0] == '0) && (plane_i[1] == '0) && (plane_i[2] == '0);

  // product stage, payload only
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      dist_q <= plane_i[3];
      zero_q <= zero_d;
    end
  end

  // d is aligned to the Q32.32 product scale; sum is exact in 67 bits
  always_comb begin
    acc = {{18{dist_q[32]}}, dist_q, 16'b0};
    for (int a = 0; a < fac_pkg::NumAxes; a++) begin
      acc = acc + fac_pkg::acc_t'(prod_q[a]);
    end
  end

  // a zero normal never rejects
  assign reject_o = !zero_q && acc[66];

endmodule

>>> hdl/frustum_aabb_cull_unit.sv
// ----------------------------------------------------------------------------
// Frustum cull unit
// Culls axis-aligned boxes against six planes taken from the view matrix.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while the result side keeps up. A load
// transaction (op 0) writes one component of all six planes as it leaves the
// input register; a test transaction (op 1) presents its visible bit after
// three register stages: input register, plane products (three 33x32
// multipliers per plane, all six planes in parallel), then exact sum, sign
// and result register. Loads and tests are handled strictly in order, so a
// test sees every load accepted before it. All planes are zero after reset,
// which makes every box visible until the matrix is loaded. A stalled result
// stalls the whole pipe; ready falls only while the result register is full
// and not taken.
// ----------------------------------------------------------------------------
`include "frustum_aabb_cull_unit_assert.svh"

module frustum_aabb_cull_unit (
  input  logic clk_i,
  input  logic rst_ni,
  fac_in_if.sink    in_i,
  fac_out_if.source out_o
);

  logic en;

  // input register
  logic            v1_q;
  logic            op1_q;
  logic [1:0]      col_index1_q;
  fac_pkg::coord_t elem1_q    [fac_pkg::NumComps];
  fac_pkg::coord_t box_min1_q [fac_pkg::NumAxes];
  fac_pkg::coord_t box_max1_q [fac_pkg::NumAxes];

  // product stage and result register
  logic v2_q;
  logic res_valid_q;
  logic visible_q;

  fac_pkg::comp_t planes [fac_pkg::NumPlanes][fac_pkg::NumComps];
  logic [fac_pkg::NumPlanes-1:0] reject;

  // pipe advances unless a finished result is held back
  assign en       = !res_valid_q || out_o.ready;
  assign in_i.ready = en;

  // control valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_i.valid;
      v2_q        <= v1_q && (op1_q == fac_pkg::OP_TEST);
      res_valid_q <= v2_q;
    end
  end

  // input payload capture
  always_ff @(posedge clk_i) begin
    if (en && in_i.valid) begin
      op1_q         <= in_i.op;
      col_index1_q  <= in_i.col_index;
      elem1_q[0]    <= in_i.col_elem0;
      elem1_q[1]    <= in_i.col_elem1;
      elem1_q[2]    <= in_i.col_elem2;
      elem1_q[3]    <= in_i.col_elem3;
      box_min1_q[0] <= in_i.box_min_x;
      box_min1_q[1] <= in_i.box_min_y;
      box_min1_q[2] <= in_i.box_min_z;
      box_max1_q[0] <= in_i.box_max_x;
      box_max1_q[1] <= in_i.box_max_y;
      box_max1_q[2] <= in_i.box_max_z;
    end
  end

  // plane store, written when a load leaves the input register
  fac_plane_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (en && v1_q && (op1_q == fac_pkg::OP_LOAD)),
    .col_index_i (col_index1_q),
    .elem_i      (elem1_q),
    .plane_o     (planes)
  );

  // six plane tests side by side
  for (genvar p = 0; p < fac_pkg::NumPlanes; p++) begin : g_lane
    fac_plane_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .plane_i   (planes[p]),
      .box_min_i (box_min1_q),
      .box_max_i (box_max1_q),
      .reject_o  (reject[p])
    );
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (en) begin
      visible_q <= ~|reject;
    end
  end

  assign out_o.valid   = res_valid_q;
  assign out_o.visible = visible_q;

  // checks
  `FAC_ASSERT_NEXT(a_test_reaches_result, clk_i, rst_ni, en && v2_q, res_valid_q,
                   "test lost before result")
  `FAC_ASSERT_NEXT(a_load_no_result, clk_i, rst_ni,
                   en && v1_q && (op1_q == fac_pkg::OP_LOAD), !v2_q,
                   "load produced a result slot")
  `FAC_ASSERT_NEXT(a_bubble_stays_empty, clk_i, rst_ni, en && !v1_q, !v2_q,
                   "result slot invented from a bubble")

endmodule

>>> dv/frustum_aabb_cull_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frustum cull unit testbench
// Sends matrix column loads and box tests, predicts each box's visibility with
// an exact fixed-point plane model, and checks every result in order.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_unit_tb;
  import fac_pkg::*;

  localparam coord_t QOne = 32'sh0001_0000;
  localparam coord_t QMin = 32'sh8000_0000;
  localparam coord_t QMax = 32'sh7fff_ffff;
  localparam int unsigned WatchdogLimit = 500;
  localparam int unsigned DrainCycles = 8;

  // one input transaction, load and box fields together
  typedef struct {
    logic       op;
    logic [1:0] col_index;
    coord_t     col [4];
    coord_t     bmin [3];
    coord_t     bmax [3];
  } cull_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fac_in_if  in_ch ();
  fac_out_if out_ch ();

  frustum_aabb_cull_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // plane copy, visibility results in flight, error count
  comp_t       planes [NumPlanes][NumComps];
  logic        visible_q [$];
  logic        want_visible;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;
  logic        idle_en = 1'b0;
  logic        stall_en = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Plane model
  // --------------------------------------------------------------------------

  // column j writes component j of all six planes: e3 +/- e0, e1, e2
  function automatic void load_column(logic [1:0] j, coord_t e0, coord_t e1,
                                      coord_t e2, coord_t e3);
    coord_t e [3];
    comp_t  base;
    comp_t  other;
    e[0] = e0;
    e[1] = e1;
    e[2] = e2;
    base = comp_t'(e3);
    for (int p = 0; p < NumPlanes; p++) begin
      other = comp_t'(e[p >> 1]);
      planes[p][j] = (p & 1) ? base - other : base + other;
    end
  endfunction

  // exact n.corner + d per plane, corner picked along the normal
  function automatic logic box_visible(coord_t x0, coord_t y0, coord_t z0,
                                       coord_t x1, coord_t y1, coord_t z1);
    coord_t lo [3];
    coord_t hi [3];
    acc_t   sum;
    acc_t   a;
    acc_t   b;
    logic   vis;
    lo[0] = x0; lo[1] = y0; lo[2] = z0;
    hi[0] = x1; hi[1] = y1; hi[2] = z1;
    vis = 1'b1;
    for (int p = 0; p < NumPlanes; p++) begin
      // zero normal never rejects
      if (planes[p][0] == 0 && planes[p][1] == 0 && planes[p][2] == 0) continue;
      sum = acc_t'(planes[p][3]);
      sum = sum <<< 16;
      for (int k = 0; k < NumAxes; k++) begin
        a = acc_t'(planes[p][k]);
        b = acc_t'((planes[p][k] >= 0) ? hi[k] : lo[k]);
        sum = sum + a * b;
      end
      if (sum < 0) vis = 1'b0;
    end
    return vis;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: results first, then the transaction accepted on the input
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (visible_q.size() == 0) begin
          $error("visible: expected none pending, actual %0d", out_ch.visible);
          err_cnt++;
        end else begin
          want_visible = visible_q.pop_front();
          if (out_ch.visible !== want_visible) begin
            $error("visible: expected %0d, actual %0d", want_visible, out_ch.visible);
            err_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_TEST) begin
          visible_q.push_back(box_visible(in_ch.box_min_x, in_ch.box_min_y,
                                          in_ch.box_min_z, in_ch.box_max_x,
                                          in_ch.box_max_y, in_ch.box_max_z));
        end else begin
          load_column(in_ch.col_index, in_ch.col_elem0, in_ch.col_elem1,
                      in_ch.col_elem2, in_ch.col_elem3);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side ready, with random stall bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else if (stall_en && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 14);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic coord_t rand_signed(int unsigned span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  // every field random over its full range
  function automatic cull_item_t rand_fields();
    cull_item_t it;
    it.op = 1'($urandom_range(0, 1));
    it.col_index = 2'($urandom_range(0, 3));
    for (int i = 0; i < 4; i++) it.col[i] = coord_t'($urandom);
    for (int i = 0; i < NumAxes; i++) begin
      it.bmin[i] = coord_t'($urandom);
      it.bmax[i] = coord_t'($urandom);
    end
    return it;
  endfunction

  // drive one transaction and hold it until accepted
  task automatic send_item(cull_item_t it);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= it.op;
    in_ch.col_index <= it.col_index;
    in_ch.col_elem0 <= it.col[0];
    in_ch.col_elem1 <= it.col[1];
    in_ch.col_elem2 <= it.col[2];
    in_ch.col_elem3 <= it.col[3];
    in_ch.box_min_x <= it.bmin[0];
    in_ch.box_min_y <= it.bmin[1];
    in_ch.box_min_z <= it.bmin[2];
    in_ch.box_max_x <= it.bmax[0];
    in_ch.box_max_y <= it.bmax[1];
    in_ch.box_max_z <= it.bmax[2];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_load(logic [1:0] j, coord_t e0, coord_t e1, coord_t e2,
                           coord_t e3);
    cull_item_t it;
    it = rand_fields();
    it.op = OP_LOAD;
    it.col_index = j;
    it.col[0] = e0;
    it.col[1] = e1;
    it.col[2] = e2;
    it.col[3] = e3;
    send_item(it);
  endtask

  task automatic send_box(coord_t x0, coord_t y0, coord_t z0, coord_t x1,
                          coord_t y1, coord_t z1);
    cull_item_t it;
    it = rand_fields();
    it.op = OP_TEST;
    it.bmin[0] = x0; it.bmin[1] = y0; it.bmin[2] = z0;
    it.bmax[0] = x1; it.bmax[1] = y1; it.bmax[2] = z1;
    send_item(it);
  endtask

  // drop valid and wait until every pending result is out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (visible_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // all planes zero after reset: every box passes
  task automatic test_reset_state();
    send_box(QMin, QMin, QMin, QMax, QMax, QMax);
    send_box(QMax, QMax, QMax, QMin, QMin, QMin);
    send_box(0, 0, 0, 0, 0, 0);
  endtask

  // extreme matrix elements push components and products to full width
  task automatic test_extreme_columns();
    send_load(0, QMin, QMax, QMin, QMax);
    send_load(1, QMax, QMin, 0, QMin);
    send_load(2, -1, 1, QMax, QMin);
    send_load(3, QMax, QMax, QMin, QMin);
    send_box(QMin, QMin, QMin, QMin, QMin, QMin);
    send_box(QMax, QMax, QMax, QMax, QMax, QMax);
  endtask

  // planes with zero normal and negative d never reject
  task automatic test_zero_normal();
    send_load(0, 0, 0, 0, 0);
    send_load(1, 0, 0, 0, 0);
    send_load(2, 0, 0, 0, 0);
    send_load(3, QMin, QMin, QMin, QMin);
    send_box(QMin, 0, QMax, 0, QMin, 0);
    // right plane keeps a zero normal while the others gain an x component
    send_load(0, QOne, 0, 0, QOne);
    send_load(3, QMax, 0, 0, QMin);
    send_box(-QOne, -QOne, -QOne, QOne, QOne, QOne);
    send_box(QMin, QMin, QMin, -QOne, -QOne, -QOne);
  endtask

  // min corner above max corner is taken as given
  task automatic test_inverted_box();
    send_load(0, QOne, 0, 0, 0);
    send_load(3, 0, 0, 0, QOne);
    send_box(QOne, QOne, QOne, -QOne, -QOne, -QOne);
    send_box(3 * QOne, 0, 0, -3 * QOne, 0, 0);
  endtask

  // mostly full matrix loads followed by boxes, some noise and partial loads
  task automatic test_random_frustums(int unsigned n_items);
    int unsigned sent;
    int unsigned mode;
    int unsigned n_box;
    int unsigned skip_col;
    int          order [4];
    int          tmp;
    int          r;
    coord_t      m [4][4];
    coord_t      c [3];
    coord_t      h [3];
    cull_item_t  it;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        mode = $urandom_range(0, 2);
        for (int j = 0; j < 4; j++) begin
          for (int k = 0; k < 4; k++) begin
            case (mode)
              0: m[j][k] = ((j == k) ? QOne : 0) + rand_signed(16384);
              1: m[j][k] = rand_signed(2 * 65536);
              default: m[j][k] = ($urandom_range(0, 3) == 0) ? coord_t'($urandom)
                                                              : rand_signed(65536);
            endcase
          end
        end
        order = '{0, 1, 2, 3};
        for (int i = 3; i > 0; i--) begin
          r = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[r];
          order[r] = tmp;
        end
        // now and then one column is left out
        skip_col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
        for (int i = 0; i < 4; i++) begin
          if (order[i] != skip_col) begin
            send_load(2'(order[i]), m[order[i]][0], m[order[i]][1],
                      m[order[i]][2], m[order[i]][3]);
            sent++;
          end
        end
        n_box = $urandom_range(3, 8);
        for (int b = 0; b < n_box; b++) begin
          if ($urandom_range(0, 5) == 0) begin
            for (int k = 0; k < 3; k++) begin
              c[k] = coord_t'($urandom);
              h[k] = coord_t'($urandom);
            end
            send_box(c[0], c[1], c[2], h[0], h[1], h[2]);
          end else begin
            for (int k = 0; k < 3; k++) begin
              c[k] = rand_signed(3 * 65536);
              h[k] = coord_t'($urandom_range(0, 65536));
              if ($urandom_range(0, 9) == 0) h[k] = -h[k];
            end
            send_box(c[0] - h[0], c[1] - h[1], c[2] - h[2],
                     c[0] + h[0], c[1] + h[1], c[2] + h[2]);
          end
          sent++;
        end
      end else begin
        n_box = $urandom_range(1, 4);
        for (int i = 0; i < n_box; i++) begin
          it = rand_fields();
          send_item(it);
          sent++;
        end
      end
    end
  endtask

  // sender holds off until the pipe is empty, then resumes with boxes
  task automatic test_sender_hold();
    drain_results();
    for (int i = 0; i < 4; i++) begin
      send_box(rand_signed(65536), rand_signed(65536), rand_signed(65536),
               rand_signed(65536), rand_signed(65536), rand_signed(65536));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int p = 0; p < NumPlanes; p++)
      for (int k = 0; k < NumComps; k++) planes[p][k] = '0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_LOAD;
    in_ch.col_index <= '0;
    in_ch.col_elem0 <= '0;
    in_ch.col_elem1 <= '0;
    in_ch.col_elem2 <= '0;
    in_ch.col_elem3 <= '0;
    in_ch.box_min_x <= '0;
    in_ch.box_min_y <= '0;
    in_ch.box_min_z <= '0;
    in_ch.box_max_x <= '0;
    in_ch.box_max_y <= '0;
    in_ch.box_max_z <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_extreme_columns();
    test_zero_normal();
    test_inverted_box();

    idle_en  <= 1'b1;
    stall_en <= 1'b1;
    test_random_frustums(250);
    test_sender_hold();
    test_random_frustums(250);

    // last stretch at full rate
    idle_en  <= 1'b0;
    stall_en <= 1'b0;
    test_random_frustums(100);

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
